// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use names the clock and the
// active-low reset so that the check is held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequence holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/dwss_pkg.sv
package dwss_pkg;

    localparam int SCORE_W    = 8;
    localparam int POS_W      = 16;
    localparam int COORD_W    = 17;
    localparam int WIN_REG_W  = 7;
    localparam int THR_W      = 14;
    localparam int TOTAL_W    = 15;
    localparam int CFG_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Input tdata: pair_score, pos_a, pos_b. Output tdata: four coordinates.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;
    localparam int M_PAD_W   = M_TDATA_W - 4 * COORD_W;

    localparam logic [WIN_REG_W-1:0] WINDOW_SIZE_RESET = 7'd10;
    localparam logic [THR_W-1:0]     THRESHOLD_RESET   = 14'd23;

    typedef enum logic
    {
        REG_WINDOW_SIZE = 1'b0,
        REG_THRESHOLD   = 1'b1
    } cfg_reg_t;

endpackage

// File: hw/rtl/dwss_ram.sv
module dwss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read-first: a read of the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/diagonal_window_score_segmenter.sv
// An accepted pair is held in the input register, then processed into the result register.
// Throughput: one pair per cycle while the output is not stalled; the window sum
// is one add, subtract and compare between the input register and the result
// register; the delay-line RAM is read ahead from the next pointer and window size.
// Reset: rst_n clears the run state, the pointer and the valid flags of both pipeline
// stages at once; the delay-line RAM is not cleared, an entry is read only once written.
`include "assert_macros.svh"

module diagonal_window_score_segmenter #(
    parameter int MAX_WINDOW  = 64,
    parameter int MAX_SEQ_LEN = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dwss_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [dwss_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dwss_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0: pair_score[7:0], pos_a[15:0], pos_b[15:0]
    input  logic [dwss_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,   // last_of_diagonal
    // s_tuser from bit 0: first_of_diagonal
    input  logic [0:0]                          s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata from bit 0: seg_start_a, seg_start_b, seg_end_a, seg_end_b, zero pad
    output logic [dwss_pkg::M_TDATA_W-1:0]      m_tdata
);

    import dwss_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int IW = AW + 1;
    localparam int SW = $clog2(MAX_SEQ_LEN);
    localparam int MW = ((SW > POS_W) ? SW : POS_W) + 2;
    // The quotient of a position by the sequence length stays below 2^9,
    // since the length is at least 256.
    localparam int QW = 9;
    localparam int PW = POS_W + QW;
    localparam int RECIP = (1 << POS_W) / MAX_SEQ_LEN;
    localparam logic [QW-1:0] RECIP_C = QW'(RECIP);

    // Configuration registers
    logic [WIN_REG_W-1:0] window_size_reg;
    logic [THR_W-1:0]     threshold_reg;
    logic                 cfg_write;

    // Input stage
    logic                 in_valid_reg;
    logic [SCORE_W-1:0]   in_score_reg;
    logic [POS_W-1:0]     in_pos_a_reg;
    logic [POS_W-1:0]     in_pos_b_reg;
    logic                 in_first_reg;
    logic                 in_last_reg;
    logic [QW-1:0]        in_quot_a_reg;
    logic [QW-1:0]        in_quot_b_reg;
    logic [PW-1:0]        prod_a;
    logic [PW-1:0]        prod_b;

    // Window and run state
    logic [AW-1:0]        ptr_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [WW-1:0]        fill_count_reg;
    logic                 run_open_reg;
    logic [SW-1:0]        run_start_a_reg;
    logic [SW-1:0]        run_start_b_reg;
    logic                 byp_hit_reg;
    logic [SCORE_W-1:0]   byp_data_reg;

    // Result stage
    logic                 out_valid_reg;
    logic [COORD_W-1:0]   out_start_a_reg;
    logic [COORD_W-1:0]   out_start_b_reg;
    logic [COORD_W-1:0]   out_end_a_reg;
    logic [COORD_W-1:0]   out_end_b_reg;

    logic                 process;
    logic [WW-1:0]        win_eff;
    logic [AW-1:0]        ptr_inc;
    logic [AW-1:0]        ptr_next;
    logic [IW-1:0]        rd_sum;
    logic [AW-1:0]        rd_addr;
    logic [SCORE_W-1:0]   ram_rdata;
    logic [SCORE_W-1:0]   old_score;
    logic [WW-1:0]        fill_base;
    logic [WW-1:0]        fill_next;
    logic [TOTAL_W-1:0]   total_base;
    logic [TOTAL_W-1:0]   total_next;
    logic [TOTAL_W-1:0]   thr_ext;
    logic                 open_base;
    logic                 full_pre;
    logic                 full_post;
    logic                 below;
    logic                 close_emit;
    logic                 open_fire;
    logic                 open_next;
    logic                 emit;
    logic [SW-1:0]        start_a_next;
    logic [SW-1:0]        start_b_next;
    logic [COORD_W-1:0]   seg_start_a;
    logic [COORD_W-1:0]   seg_start_b;
    logic [COORD_W-1:0]   seg_end_a;
    logic [COORD_W-1:0]   seg_end_b;

    // Zero-based run start: (pos - (win - 1)) modulo the sequence length.
    // The quotient estimate from the input stage is low by at most one.
    function automatic logic [SW-1:0] run_start_of(
        input logic [POS_W-1:0] pos,
        input logic [QW-1:0]    quot,
        input logic [WW-1:0]    win
    );
        logic [MW-1:0] rem;
        logic [MW-1:0] back;
        rem  = MW'(pos) - MW'(quot) * MW'(MAX_SEQ_LEN);
        if (rem >= MW'(MAX_SEQ_LEN))
        begin
            rem = rem - MW'(MAX_SEQ_LEN);
        end
        back = MW'(win) - MW'(1);
        if (rem >= back)
        begin
            rem = rem - back;
        end
        else
        begin
            rem = rem + MW'(MAX_SEQ_LEN) - back;
        end
        return rem[SW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
            threshold_reg   <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(paddr[2]))
                REG_WINDOW_SIZE: window_size_reg <= pwdata[WIN_REG_W-1:0];
                REG_THRESHOLD:   threshold_reg   <= pwdata[THR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_reg_t'(paddr[2]))
            REG_WINDOW_SIZE: prdata = APB_DATA_W'(window_size_reg);
            REG_THRESHOLD:   prdata = APB_DATA_W'(threshold_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------
    assign process  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || process;

    assign prod_a = PW'(s_tdata[SCORE_W +: POS_W]) * PW'(RECIP_C);
    assign prod_b = PW'(s_tdata[SCORE_W + POS_W +: POS_W]) * PW'(RECIP_C);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_score_reg  <= s_tdata[SCORE_W-1:0];
            in_pos_a_reg  <= s_tdata[SCORE_W +: POS_W];
            in_pos_b_reg  <= s_tdata[SCORE_W + POS_W +: POS_W];
            in_first_reg  <= s_tuser[0];
            in_last_reg   <= s_tlast;
            in_quot_a_reg <= prod_a[PW-1:POS_W];
            in_quot_b_reg <= prod_b[PW-1:POS_W];
        end
    end

    // ------------------------------------------------------------------
    // Delay line
    // ------------------------------------------------------------------
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = WW'(1);
        end
        else if (int'(window_size_reg) > MAX_WINDOW)
        begin
            win_eff = WW'(MAX_WINDOW);
        end
        else
        begin
            win_eff = WW'(window_size_reg);
        end
    end

    assign ptr_inc  = (ptr_reg == AW'(MAX_WINDOW - 1)) ? '0 : ptr_reg + AW'(1);
    assign ptr_next = process ? ptr_inc : ptr_reg;

    // The read for the next transaction is issued from the pointer it will see.
    assign rd_sum  = (IW'(ptr_next) >= IW'(win_eff)) ?
                     IW'(ptr_next) - IW'(win_eff) :
                     IW'(ptr_next) + IW'(MAX_WINDOW) - IW'(win_eff);
    assign rd_addr = rd_sum[AW-1:0];

    dwss_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_WINDOW)
    ) u_delay_line (
        .clk   (clk),
        .we    (process),
        .waddr (ptr_reg),
        .wdata (in_score_reg),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // With a window of one the entry read is the one written in the same cycle.
    assign old_score = byp_hit_reg ? byp_data_reg : ram_rdata;

    // ------------------------------------------------------------------
    // Window sum and run tracking
    // ------------------------------------------------------------------
    always_comb
    begin
        fill_base  = in_first_reg ? '0 : fill_count_reg;
        total_base = in_first_reg ? '0 : total_reg;
        open_base  = in_first_reg ? 1'b0 : run_open_reg;

        full_pre   = fill_base >= win_eff;
        total_next = total_base +
                     {{(TOTAL_W - SCORE_W){in_score_reg[SCORE_W-1]}}, in_score_reg};
        if (full_pre)
        begin
            total_next = total_next -
                         {{(TOTAL_W - SCORE_W){old_score[SCORE_W-1]}}, old_score};
        end

        fill_next = (fill_base == WW'(MAX_WINDOW)) ? fill_base : fill_base + WW'(1);
        full_post = fill_next >= win_eff;

        thr_ext = {{(TOTAL_W - THR_W){threshold_reg[THR_W-1]}}, threshold_reg};
        below   = $signed(total_next) < $signed(thr_ext);

        close_emit = full_post && open_base && below;
        open_fire  = full_post && !open_base && !below;
        open_next  = (open_base && !close_emit) || open_fire;
        emit       = close_emit || (in_last_reg && open_next);

        start_a_next = open_fire ?
                       run_start_of(in_pos_a_reg, in_quot_a_reg, win_eff) : run_start_a_reg;
        start_b_next = open_fire ?
                       run_start_of(in_pos_b_reg, in_quot_b_reg, win_eff) : run_start_b_reg;

        seg_start_a = COORD_W'(MW'(start_a_next) + MW'(1));
        seg_start_b = COORD_W'(MW'(start_b_next) + MW'(1));

        // A run closed by the sum ends at the previous pair; one closed by
        // the end of the diagonal ends at this pair.
        if (close_emit)
        begin
            seg_end_a = COORD_W'(in_pos_a_reg);
            seg_end_b = COORD_W'(in_pos_b_reg);
        end
        else
        begin
            seg_end_a = COORD_W'(in_pos_a_reg) + COORD_W'(1);
            seg_end_b = COORD_W'(in_pos_b_reg) + COORD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg         <= '0;
            total_reg       <= '0;
            fill_count_reg  <= '0;
            run_open_reg    <= 1'b0;
            run_start_a_reg <= '0;
            run_start_b_reg <= '0;
            byp_hit_reg     <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= process && (ptr_reg == rd_addr);
            if (process)
            begin
                ptr_reg         <= ptr_inc;
                total_reg       <= in_last_reg ? '0 : total_next;
                fill_count_reg  <= in_last_reg ? '0 : fill_next;
                run_open_reg    <= in_last_reg ? 1'b0 : open_next;
                run_start_a_reg <= start_a_next;
                run_start_b_reg <= start_b_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= in_score_reg;
    end

    // ------------------------------------------------------------------
    // Result stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && emit)
        begin
            out_start_a_reg <= seg_start_a;
            out_start_b_reg <= seg_start_b;
            out_end_a_reg   <= seg_end_a;
            out_end_b_reg   <= seg_end_b;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_end_b_reg, out_end_a_reg,
                       out_start_b_reg, out_start_a_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_ptr_range, clk, rst_n, ptr_reg <= AW'(MAX_WINDOW - 1), "pointer out of range")
    `ASSERT_IMPLIES(a_open_has_fill, clk, rst_n, run_open_reg, fill_count_reg != '0, "run open on empty window")
    `ASSERT_NEXT(a_last_clears, clk, rst_n, process && in_last_reg, !run_open_reg && (fill_count_reg == '0) && (total_reg == '0), "diagonal end did not clear the window")
    `ASSERT_IMPLIES(a_out_from_process, clk, rst_n, $rose(m_tvalid), $past(process), "result appeared without a processed transaction")

endmodule
